// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/isort_pkg.sv =====
// ----------------------------------------------------------------------------
// isort_pkg
// shared constants and types of the insertion sorter
// ----------------------------------------------------------------------------
package isort_pkg;

   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;

   // request queue between front and back, power of two deep
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } isort_item_type;

endpackage

// ===== rtl/isort_queue.sv =====
// ----------------------------------------------------------------------------
// isort_queue
// front end: accepts requests and buffers them for the sort core
// ----------------------------------------------------------------------------
module isort_queue import isort_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  isort_item_type req_item,
   output logic           q_valid,
   input  logic           q_pop,
   output isort_item_type q_item
);

   isort_item_type      mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                push;
   logic                pop;

   assign req_ready = (cnt_ff != QCNT_W'(QDEPTH));
   assign q_valid   = (cnt_ff != '0);
   assign q_item    = mem_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

// ===== rtl/isort_core.sv =====
// ----------------------------------------------------------------------------
// isort_core
// back end: compare-and-shift cell row, drain sequencer and output register
// ----------------------------------------------------------------------------
module isort_core import isort_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   output logic                      q_pop,
   input  isort_item_type            q_item,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_value_res,
   output logic                      rsp_last_res,
   output logic                      rsp_overflow
);

   localparam logic ST_FILL  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic                      state_ff, state_in;
   logic [CNT_W-1:0]          fill_ff, fill_in;
   logic                      dropped_ff, dropped_in;
   logic signed [VALUE_W-1:0] cells_ff [DEPTH];
   logic signed [VALUE_W-1:0] cells_in [DEPTH];
   logic                      ins [DEPTH];
   logic                      full;
   logic                      out_load;
   logic                      emit;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_last_ff;
   logic                      rsp_ovf_ff;

   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign q_pop    = (state_ff == ST_FILL);
   assign out_load = !rsp_valid_ff || rsp_ready;
   assign emit     = (state_ff == ST_DRAIN) && out_load;

   // cell i takes a new value where the incoming one sorts strictly before it,
   // or where it is the first free cell; equal values stay ahead
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ins[i] = (CNT_W'(i) == fill_ff) ||
                  ((CNT_W'(i) < fill_ff) && (q_item.value < cells_ff[i]));
      end
   end

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      dropped_in = dropped_ff;
      for (int i = 0; i < DEPTH; i++) begin
         cells_in[i] = cells_ff[i];
      end
      case (state_ff)
         ST_FILL: begin
            if (q_valid) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  fill_in = fill_ff + 1'b1;
                  for (int i = 0; i < DEPTH; i++) begin
                     if (ins[i]) begin
                        if (i > 0 && ins[(i > 0) ? i - 1 : 0]) begin
                           cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
                        end else begin
                           cells_in[i] = q_item.value;
                        end
                     end
                  end
               end
               if (q_item.last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (out_load) begin
               for (int i = 0; i < DEPTH - 1; i++) begin
                  cells_in[i] = cells_ff[i + 1];
               end
               fill_in = fill_ff - 1'b1;
               if (fill_ff == CNT_W'(1)) begin
                  state_in   = ST_FILL;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_ff      <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         cells_ff[i] <= cells_in[i];
      end
      if (emit) begin
         rsp_value_ff <= cells_ff[0];
         rsp_last_ff  <= (fill_ff == CNT_W'(1));
         rsp_ovf_ff   <= dropped_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_last_res  = rsp_last_ff;
   assign rsp_overflow  = rsp_ovf_ff;

endmodule

// ===== rtl/insertion_sorter.sv =====
// flow: a request is registered in the queue and enters the cell row when the
// core pops it while filling; once the last request of a set arrives, the core
// drains through the output register, one result per cycle while rsp_ready holds
// throughput: one request per cycle while filling; while a set of stored values
// drains from the cell row, at most two requests wait in the queue
// reset: synchronous, active high; empties the queue, the row and the output
// ----------------------------------------------------------------------------
// insertion_sorter
// streaming stable insertion sort of signed values, emitted when a set closes
// ----------------------------------------------------------------------------
module insertion_sorter import isort_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_value_res,
   output logic                      rsp_last_res,
   output logic                      rsp_overflow
);

   isort_item_type req_item;
   isort_item_type q_item;
   logic           q_valid;
   logic           q_pop;

   assign req_item.value = req_value;
   assign req_item.last  = req_last;

   isort_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item)
   );

   isort_core u_core (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .q_item        (q_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_res (rsp_value_res),
      .rsp_last_res  (rsp_last_res),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

// ===== rtl/isort_checker.sv =====
// ----------------------------------------------------------------------------
// isort_checker
// port-level checks of the insertion sorter, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module isort_checker import isort_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic signed [VALUE_W-1:0] req_value,
   input logic                      req_last,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [VALUE_W-1:0] rsp_value_res,
   input logic                      rsp_last_res,
   input logic                      rsp_overflow
);

   logic                      rsp_take;
   logic                      in_set_ff, in_set_in;
   logic signed [VALUE_W-1:0] prev_ff, prev_in;
   logic                      ovf_ff, ovf_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   assign rsp_take = rsp_valid && rsp_ready;

   // track the results already taken in the current set
   always_comb begin
      in_set_in = in_set_ff;
      prev_in   = prev_ff;
      ovf_in    = ovf_ff;
      cnt_in    = cnt_ff;
      if (rsp_take) begin
         in_set_in = !rsp_last_res;
         prev_in   = rsp_value_res;
         ovf_in    = rsp_overflow;
         cnt_in    = rsp_last_res ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_set_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         in_set_ff <= in_set_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      ovf_ff  <= ovf_in;
   end

   `CHK_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_value) && $stable(req_last))
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value_res) && $stable(rsp_last_res) && $stable(rsp_overflow))
   `CHK_IMPLY(a_ascending, clock, reset, rsp_valid && in_set_ff, rsp_value_res >= prev_ff)
   `CHK_IMPLY(a_ovf_const, clock, reset, rsp_valid && in_set_ff, rsp_overflow == ovf_ff)
   `CHK_IMPLY(a_set_size, clock, reset, rsp_valid, cnt_ff < CNT_W'(DEPTH))

endmodule

bind insertion_sorter isort_checker u_isort_checker (.*);
